// ===== src/pseudo_heading_angle_macros.svh =====
// assertion macros for the pseudo heading angle block
// used by modules under src that check their own pipeline logic
`ifndef PSEUDO_HEADING_ANGLE_MACROS_SVH
`define PSEUDO_HEADING_ANGLE_MACROS_SVH
`ifndef SYNTHESIS
`define PHA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pha assertion failed");
`define PHA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pha implication failed");
`else
`define PHA_ASSERT(lbl, clk, rstn, prop)
`define PHA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/pha_pkg.sv =====
// constants and tangent table for the pseudo heading angle block
// no dependencies
package pha_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int RATIO_SCALE     = 10000;
  localparam int SMALL_RATIO     = 1000;
  localparam int SMALL_GAIN      = 57;
  localparam int STEP_DEG        = 5;
  localparam int QUARTER_TURN    = 90;
  localparam int HALF_TURN       = 180;
  localparam int FULL_TURN       = 360;
  localparam int RATIO_W         = 14;
  localparam int SPAN_W          = 11;
  localparam int IDX_W           = 4;
  localparam int FINE_QW         = 3;
  localparam int DEG_W           = 9;
  localparam int ANG_W           = 7;

  localparam logic [RATIO_W-1:0] TAN_TABLE [9] = '{
    14'd875, 14'd1763, 14'd2679, 14'd3640, 14'd4663,
    14'd5774, 14'd7002, 14'd8391, 14'd10000
  };
endpackage

// ===== src/pha_pipe_div.sv =====
// pipelined restoring divider, one quotient bit per register stage
// depends on pha_pkg and pseudo_heading_angle_macros.svh
`include "pseudo_heading_angle_macros.svh"
module pha_pipe_div import pha_pkg::*; #(
  parameter int NW = 30,
  parameter int DW = 16,
  parameter int QW = 14,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);
  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_q    [QW];
  logic [NW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quot_q [QW];
  logic [SW-1:0] side_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic          v_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quot_in;
    logic [SW-1:0] side_in;
    logic [XW-1:0] rem_x, div_x;
    logic          ge;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_rest
      assign v_in    = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign den_in  = den_q[j-1];
      assign quot_in = quot_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign rem_x = XW'(rem_in);
    assign div_x = XW'(den_in) << K;
    assign ge    = (rem_x >= div_x);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? NW'(rem_x - div_x) : rem_in;
        den_q[j]  <= den_in;
        quot_q[j] <= ge ? (quot_in | (QW'(1) << K)) : quot_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign side_o  = side_q[QW-1];

  `PHA_ASSERT_IMPL(a_div_hold, clk_i, rst_ni, !en_i, ##1 (valid_o == $past(valid_o)))
  `PHA_ASSERT_IMPL(a_div_quot_hold, clk_i, rst_ni, !en_i && valid_o, ##1 $stable(quot_o))
  `PHA_ASSERT_IMPL(a_div_flow, clk_i, rst_ni, en_i && valid_i, ##1 v_q[0])
endmodule

// ===== src/pseudo_heading_angle.sv =====
// heading in whole degrees; throughput one transaction per cycle while the output
// is not stalled; two pipelined restoring dividers (14 and 3 stages) set the depth,
// plus entry, table search and output registers
// a stalled output freezes the whole pipeline; nothing is lost or repeated
// asynchronous active-low reset clears all valid bits; payload registers are not reset
`include "pseudo_heading_angle_macros.svh"
module pseudo_heading_angle import pha_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic [COORD_WIDTH-1:0] from_x_i,
  input  logic [COORD_WIDTH-1:0] from_y_i,
  input  logic [COORD_WIDTH-1:0] to_x_i,
  input  logic [COORD_WIDTH-1:0] to_y_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output logic [DEG_W-1:0]       heading_deg_o
);
  localparam int CW   = COORD_WIDTH;
  localparam int NW1  = CW + RATIO_W;
  localparam int SNW  = (CW + 6 > RATIO_W) ? CW + 6 : RATIO_W;
  localparam int DW2  = (CW > SPAN_W) ? CW : SPAN_W;

  typedef struct packed {
    logic xlt;
    logic yle;
    logic ylt;
    logic swap;
    logic zero;
  } flags_t;

  typedef struct packed {
    flags_t         f;
    logic [SNW-1:0] sn;
    logic [CW-1:0]  hi;
  } side1_t;

  typedef struct packed {
    flags_t           f;
    logic             small_sel;
    logic [IDX_W-1:0] idx;
  } side2_t;

  logic en;

  // entry stage
  logic signed [CW:0] ddx, ddy;
  logic [CW-1:0]      dx, dy, lo, hi;
  flags_t             fa;
  logic               va_q;
  logic [NW1-1:0]     numa_q;
  logic [CW-1:0]      dena_q;
  side1_t             sidea_q;

  assign en = !(valid_o && stall_i);
  assign stall_o = !en;

  assign ddx = {to_x_i[CW-1], to_x_i} - {from_x_i[CW-1], from_x_i};
  assign ddy = {to_y_i[CW-1], to_y_i} - {from_y_i[CW-1], from_y_i};
  assign dx  = ddx[CW] ? CW'(-ddx) : ddx[CW-1:0];
  assign dy  = ddy[CW] ? CW'(-ddy) : ddy[CW-1:0];

  always_comb begin
    fa.xlt  = ddx[CW];
    fa.ylt  = ddy[CW];
    fa.yle  = ddy[CW] || (dy == '0);
    fa.swap = (dy > dx);
    fa.zero = (dx == '0) && (dy == '0);
    lo = fa.swap ? dx : dy;
    hi = fa.swap ? dy : dx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numa_q     <= NW1'(lo) * NW1'(RATIO_SCALE);
      dena_q     <= hi;
      sidea_q.f  <= fa;
      sidea_q.sn <= SNW'(lo) * SNW'(SMALL_GAIN) + SNW'(hi >> 1);
      sidea_q.hi <= hi;
    end
  end

  // ratio divider
  logic               v1;
  logic [RATIO_W-1:0] r1;
  side1_t             side1;

  pha_pipe_div #(
    .NW(NW1), .DW(CW), .QW(RATIO_W), .SW($bits(side1_t))
  ) u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va_q),
    .num_i   (numa_q),
    .den_i   (dena_q),
    .side_i  (sidea_q),
    .valid_o (v1),
    .quot_o  (r1),
    .side_o  (side1)
  );

  // table search stage
  logic [IDX_W-1:0]   idx;
  logic [RATIO_W-1:0] tbase, diff;
  logic [SPAN_W-1:0]  span;
  logic [RATIO_W+2:0] prod;
  logic               small_sel;
  logic               vb_q;
  logic [SNW-1:0]     numb_q;
  logic [DW2-1:0]     denb_q;
  side2_t             sideb_q;

  always_comb begin
    idx = IDX_W'(1);
    for (int j = 1; j < 8; j++) begin
      if (TAN_TABLE[j] < r1) idx = idx + IDX_W'(1);
    end
    tbase     = TAN_TABLE[IDX_W'(idx - IDX_W'(1))];
    span      = SPAN_W'(TAN_TABLE[idx] - tbase);
    diff      = RATIO_W'(r1 - tbase);
    prod      = {3'b000, diff} * (RATIO_W + 3)'(STEP_DEG);
    small_sel = (r1 < RATIO_W'(SMALL_RATIO));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numb_q <= small_sel ? side1.sn : SNW'(prod) + SNW'(span >> 1);
      denb_q <= small_sel ? DW2'(side1.hi) : DW2'(span);
      sideb_q.f         <= side1.f;
      sideb_q.small_sel <= small_sel;
      sideb_q.idx       <= idx;
    end
  end

  // fine divider
  logic               v2;
  logic [FINE_QW-1:0] q2;
  side2_t             side2;

  pha_pipe_div #(
    .NW(SNW), .DW(DW2), .QW(FINE_QW), .SW($bits(side2_t))
  ) u_fine_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vb_q),
    .num_i   (numb_q),
    .den_i   (denb_q),
    .side_i  (sideb_q),
    .valid_o (v2),
    .quot_o  (q2),
    .side_o  (side2)
  );

  // quadrant fold and output register
  logic [ANG_W-1:0] moct, mbase;
  logic [DEG_W-1:0] m9, heading_d, heading_q;
  logic             vo_q;

  always_comb begin
    moct  = side2.small_sel ? ANG_W'(q2)
          : ANG_W'(side2.idx) * ANG_W'(STEP_DEG) + ANG_W'(q2);
    mbase = side2.f.zero ? '0
          : (side2.f.swap ? ANG_W'(ANG_W'(QUARTER_TURN) - moct) : moct);
    m9 = DEG_W'(mbase);
    if (side2.f.xlt) begin
      heading_d = side2.f.yle ? DEG_W'(m9 + DEG_W'(HALF_TURN))
                              : DEG_W'(DEG_W'(HALF_TURN) - m9);
    end else if (side2.f.ylt && (m9 != '0)) begin
      heading_d = DEG_W'(DEG_W'(FULL_TURN) - m9);
    end else begin
      heading_d = m9;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      heading_q <= heading_d;
    end
  end

  assign valid_o       = vo_q;
  assign heading_deg_o = heading_q;

  `PHA_ASSERT_IMPL(a_heading_range, clk_i, rst_ni, valid_o, heading_deg_o < DEG_W'(FULL_TURN))
  `PHA_ASSERT_IMPL(a_ratio_range, clk_i, rst_ni, v1 && !side1.f.zero, r1 <= RATIO_W'(RATIO_SCALE))
  `PHA_ASSERT_IMPL(a_fine_range, clk_i, rst_ni, v2 && !side2.f.zero, q2 <= FINE_QW'(6))
endmodule

// ===== bench/tb.sv =====
// testbench for pseudo_heading_angle: drives random and corner point pairs,
// predicts each heading and checks results in order; depends on pha_pkg and the rtl
`timescale 1ns / 100ps
module tb;
  import pha_pkg::*;

  class heading_board;
    logic [DEG_W-1:0] pending_q[$];
    int errors;
    int checked;

    function int unsigned base_angle(int unsigned lo, int unsigned hi);
      int unsigned r;
      int unsigned i;
      int unsigned span;
      r = (RATIO_SCALE * lo) / hi;
      if (r < SMALL_RATIO) return (SMALL_GAIN * lo + hi / 2) / hi;
      i = 1;
      while (i < 8 && TAN_TABLE[i] < r) i++;
      span = TAN_TABLE[i] - TAN_TABLE[i-1];
      return STEP_DEG * i + (STEP_DEG * (r - TAN_TABLE[i-1]) + span / 2) / span;
    endfunction

    function void note_points(logic signed [15:0] fx, logic signed [15:0] fy,
                              logic signed [15:0] tx, logic signed [15:0] ty);
      int x1;
      int y1;
      int x2;
      int y2;
      int unsigned dx;
      int unsigned dy;
      int unsigned m;
      x1 = fx;
      y1 = fy;
      x2 = tx;
      y2 = ty;
      dx = (x2 > x1) ? x2 - x1 : x1 - x2;
      dy = (y2 > y1) ? y2 - y1 : y1 - y2;
      if (dx == 0 && dy == 0) m = 0;
      else if (dy <= dx) m = base_angle(dy, dx);
      else m = QUARTER_TURN - base_angle(dx, dy);
      if (x2 < x1) begin
        if (y2 <= y1) m = m + HALF_TURN;
        else m = HALF_TURN - m;
      end else if (y2 < y1) begin
        m = FULL_TURN - m;
      end
      if (m == FULL_TURN) m = 0;
      pending_q.push_back(m[DEG_W-1:0]);
    endfunction

    function void check_heading(logic [DEG_W-1:0] got);
      logic [DEG_W-1:0] want;
      checked++;
      if (pending_q.size() == 0) begin
        $error("heading_deg: no transaction pending, actual %0d", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        $error("heading_deg: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic valid_i;
  logic stall_o;
  logic [15:0] from_x_i;
  logic [15:0] from_y_i;
  logic [15:0] to_x_i;
  logic [15:0] to_y_i;
  logic valid_o;
  logic stall_i;
  logic [DEG_W-1:0] heading_deg_o;

  heading_board board;
  int cycle_cnt;
  int hold_cycles;
  bit no_idle;

  pseudo_heading_angle u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 200000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) board.check_heading(heading_deg_o);
  end

  // receiver stall, with a long hold-off requested through hold_cycles
  always @(negedge clk_i) begin
    if (!rst_ni) stall_i <= 1'b0;
    else if (hold_cycles > 0) begin
      stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (no_idle) stall_i <= 1'b0;
    else stall_i <= ($urandom_range(99) < 30);
  end

  task automatic send_points(logic [15:0] fx, logic [15:0] fy,
                             logic [15:0] tx, logic [15:0] ty);
    while (!no_idle && $urandom_range(99) < 30) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    from_x_i <= fx;
    from_y_i <= fy;
    to_x_i <= tx;
    to_y_i <= ty;
    do @(posedge clk_i); while (stall_o);
    board.note_points(fx, fy, tx, ty);
    @(negedge clk_i);
  endtask

  task automatic drain;
    valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(40) - 20);
      2: return $urandom_range(1) ? 16'(16'h7fff - $urandom_range(3))
                                  : 16'(16'h8000 + $urandom_range(3));
      default: return 16'($urandom_range(2000) - 1000);
    endcase
  endfunction

  initial begin
    logic [15:0] fx;
    logic [15:0] fy;
    int d;
    board = new();
    cycle_cnt = 0;
    hold_cycles = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    stall_i = 1'b0;
    from_x_i = '0;
    from_y_i = '0;
    to_x_i = '0;
    to_y_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // corners: identical points, axes, diagonals, table entries, extremes
    send_points(0, 0, 0, 0);
    send_points(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_points(0, 0, 100, 0);
    send_points(0, 0, 0, 100);
    send_points(0, 0, 16'hff9c, 0);
    send_points(0, 0, 0, 16'hff9c);
    send_points(0, 0, 50, 50);
    send_points(0, 0, 16'hffce, 50);
    send_points(0, 0, 16'hffce, 16'hffce);
    send_points(0, 0, 50, 16'hffce);
    send_points(0, 0, 10000, 875);
    send_points(0, 0, 10000, 1763);
    send_points(0, 0, 10000, 8391);
    send_points(0, 0, 10000, 1000);
    send_points(0, 0, 10000, 999);
    send_points(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_points(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_points(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_points(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_points(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_points(0, 0, 2, 16'hffff);
    drain();

    // long receiver hold-off while items keep coming
    hold_cycles = 80;
    for (int k = 0; k < 60; k++)
      send_points(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    drain();

    for (int k = 0; k < 1500; k++) begin
      no_idle = (k >= 600 && k < 900);
      if (k % 500 == 499) drain();
      fx = rand_coord();
      fy = rand_coord();
      if ($urandom_range(3) == 0) begin
        d = $urandom_range(600) - 300;
        send_points(fx, fy, 16'(fx + d), 16'(fy + $urandom_range(600) - 300));
      end else begin
        send_points(fx, fy, rand_coord(), rand_coord());
      end
    end
    no_idle = 1'b0;
    drain();
    repeat (40) @(negedge clk_i);

    $display("covered %0d headings: corners, octant boundaries, table entries, stalls",
             board.checked);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
